// ===== rtl/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, request codes and status codes for the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int PRIO_W   = 32;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Request codes.
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_SHIFT = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                      req_type;
        logic signed [PRIO_W-1:0]  priority_req;
        logic        [FIELD_W-1:0] payload;
    } t_in_word;

    typedef struct packed {
        logic        [STATUS_W-1:0] status;
        logic signed [PRIO_W-1:0]   out_priority;
        logic        [FIELD_W-1:0]  out_payload;
        logic        [COUNT_W-1:0]  count;
    } t_out_word;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic                     push;
        logic                     shift;
        logic signed [PRIO_W-1:0] prio;
    } t_cell_ctl;

endpackage

// ===== rtl/spq_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: holds one entry, compares it against the
// broadcast priority and takes the new entry or a neighbor's entry.
// ---------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic [DATA_WIDTH-1:0]    i_new_data,
    input  logic                     i_strict,
    input  logic                     i_occ,
    input  logic                     i_left_ins,
    input  logic signed [PRIO_W-1:0] i_left_prio,
    input  logic [DATA_WIDTH-1:0]    i_left_data,
    input  logic signed [PRIO_W-1:0] i_right_prio,
    input  logic [DATA_WIDTH-1:0]    i_right_data,
    output logic                     o_ins,
    output logic signed [PRIO_W-1:0] o_prio,
    output logic [DATA_WIDTH-1:0]    o_data
);

    logic signed [PRIO_W-1:0] r_prio;
    logic [DATA_WIDTH-1:0]    r_data;
    logic signed [PRIO_W-1:0] n_prio;
    logic [DATA_WIDTH-1:0]    n_data;
    logic                     goes_before;

    // The head yields only to a strictly smaller priority; later slots yield on ties.
    assign goes_before = i_strict ? (r_prio > i_ctl.prio) : (i_ctl.prio <= r_prio);
    assign o_ins       = !i_occ || goes_before;

    always_comb begin
        n_prio = r_prio;
        n_data = r_data;
        if (i_ctl.push) begin
            if (i_left_ins) begin
                n_prio = i_left_prio;
                n_data = i_left_data;
            end else if (o_ins) begin
                n_prio = i_ctl.prio;
                n_data = i_new_data;
            end
        end else if (i_ctl.shift) begin
            n_prio = i_right_prio;
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_data <= n_data;
    end

    assign o_prio = r_prio;
    assign o_data = r_data;

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue unit
// Min-priority queue built as a chain of sorted cells, one request per word.
// ---------------------------------------------------------------------------
// The queue holds up to CAPACITY entries sorted by signed priority, smallest
// first, in a row of cells. A new word is accepted in every cycle as long as
// the result register is free or being read in that cycle; all cells update in
// parallel from a broadcast of the request, so the cell chain sets that figure
// of one word per cycle.
// Each request returns exactly one result word, in the cycle after acceptance.
// A push goes in front of the first entry whose priority is greater than or
// equal to its own, except that it passes the head only when the head's
// priority is strictly greater. A push into a full queue is dropped with the
// full status, and a shift on an empty queue returns the empty status; the
// priority and payload fields of a result are zero unless a shift succeeded.
// The count field reports the number of entries held, modulo 32.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_word        r_out_word;
    t_out_word        n_out_word;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    t_cell_ctl        ctl;
    logic [DATA_WIDTH-1:0] new_data;

    // Chain wiring; index CAPACITY is the spare right neighbor of the tail.
    logic                     ins   [CAPACITY];
    logic signed [PRIO_W-1:0] prio  [CAPACITY+1];
    logic [DATA_WIDTH-1:0]    data  [CAPACITY+1];

    // The result register frees up in the same cycle it is read, so a new
    // word can enter while the previous result is being taken.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);

    // Rejected requests are masked off so the cells stay untouched.
    assign ctl.push  = accept && (i_in_word.req_type == REQ_PUSH) && !is_full;
    assign ctl.shift = accept && (i_in_word.req_type == REQ_SHIFT) && !is_empty;
    assign ctl.prio  = i_in_word.priority_req;
    assign new_data  = DATA_WIDTH'(i_in_word.payload);

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic occ;
            logic left_ins;
            logic signed [PRIO_W-1:0] left_prio;
            logic [DATA_WIDTH-1:0]    left_data;

            assign occ = (CNT_W'(g) < r_count);

            if (g == 0) begin : g_head
                assign left_ins  = 1'b0;
                assign left_prio = prio[0];
                assign left_data = data[0];
            end else begin : g_body
                assign left_ins  = ins[g-1];
                assign left_prio = prio[g-1];
                assign left_data = data[g-1];
            end

            spq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_new_data   (new_data),
                .i_strict     (g == 0),
                .i_occ        (occ),
                .i_left_ins   (left_ins),
                .i_left_prio  (left_prio),
                .i_left_data  (left_data),
                .i_right_prio (prio[g+1]),
                .i_right_data (data[g+1]),
                .o_ins        (ins[g]),
                .o_prio       (prio[g]),
                .o_data       (data[g])
            );
        end
    endgenerate

    // The tail's right neighbor is never occupied; it simply recirculates.
    assign prio[CAPACITY] = prio[CAPACITY-1];
    assign data[CAPACITY] = data[CAPACITY-1];

    // Next count and the result word for the request being accepted.
    always_comb begin
        n_count                 = r_count;
        n_out_word.status       = ST_OK;
        n_out_word.out_priority = '0;
        n_out_word.out_payload  = '0;
        if (i_in_word.req_type == REQ_PUSH) begin
            if (is_full) begin
                n_out_word.status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (is_empty) begin
                n_out_word.status = ST_EMPTY;
            end else begin
                n_count                 = r_count - 1'b1;
                n_out_word.out_priority = prio[0];
                n_out_word.out_payload  = FIELD_W'(data[0]);
            end
        end
        n_out_word.count = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    // The fill level never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("queue count exceeds capacity");

    // A push that was not flagged full grows the queue by exactly one.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_word.req_type == REQ_PUSH && !is_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not add an entry");

    // The two front entries stay in order whenever both are held.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (prio[0] <= prio[1]))
        else $error("head entries out of order");

    // A successful shift reports the OK status and leaves the count one below the previous fill level.
    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_word.req_type == REQ_SHIFT && !is_empty)
        |=> (o_out_word.status == ST_OK && r_count == $past(r_count) - 1'b1))
        else $error("shift result inconsistent with count");
`endif

endmodule
